// ----- design/slab_free_list_allocator_defines.svh -----
// Assertion macros shared by the slab allocator checker.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef SLAB_FREE_LIST_ALLOCATOR_DEFINES_SVH
`define SLAB_FREE_LIST_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SLAB_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SLAB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/slab_pkg.sv -----
// Shared types and codes for the slab free-list allocator.
// No dependencies; used by the shift unit, the allocator and the checker through scoped names.
package slab_pkg;

    // request commands
    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    // result status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_EMPTY    = 2'd1;
    localparam logic [1:0] ST_BAD_ADDR = 2'd2;

    // shift unit operations
    localparam logic OP_MUL = 1'b0;
    localparam logic OP_DIV = 1'b1;

    // configuration register map
    localparam int         CFG_IDX_W        = 2;
    localparam logic [1:0] CFG_BASE_ADDRESS = 2'd0;
    localparam logic [1:0] CFG_SLOT_SIZE    = 2'd1;

    localparam logic [31:0] BASE_RESET = 32'd0;
    localparam logic [15:0] SIZE_RESET = 16'd16;

    typedef struct packed {
        logic        cmd;
        logic [31:0] addr;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] slot_address;
        logic [4:0]  slot_number;
        logic [5:0]  free_count;
        logic        full_res;
    } res_t;

    typedef struct packed {
        logic start;
        logic op;
    } unit_cmd_t;

endpackage

// ----- design/slab_shift_unit.sv -----
// Iterative shift-add / shift-subtract unit: multiply or restoring divide, one bit a cycle.
// Depends on slab_pkg for the operation codes and the command struct.
module slab_shift_unit #(
    parameter int QW = 6
) (
    input  logic                clk,
    input  logic                rst_n,
    input  slab_pkg::unit_cmd_t cmd,
    input  logic [31:0]         acc_init,
    input  logic [15:0]         operand,
    input  logic [QW-1:0]       multiplier,
    output logic                done,
    output logic [31:0]         acc,
    output logic [QW:0]         quotient
);

    localparam int                CNT_W = $clog2(QW + 2);
    localparam logic [CNT_W-1:0]  LAST  = CNT_W'(QW);

    logic             run_reg;
    logic             done_reg;
    logic             op_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [31:0]      acc_reg;
    logic [31:0]      b_reg;
    logic [QW:0]      q_reg;

    logic [31:0] addend;
    logic [32:0] sum;
    logic        is_div;
    logic        take;

    // one shared adder: subtract for divide, add for multiply
    assign is_div = (op_reg == slab_pkg::OP_DIV);
    assign addend = is_div ? ~b_reg : b_reg;
    assign sum    = {1'b0, acc_reg} + {1'b0, addend} + 33'(is_div);
    assign take   = is_div ? sum[32] : q_reg[QW];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            op_reg   <= slab_pkg::OP_MUL;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (cmd.start)
            begin
                run_reg <= 1'b1;
                op_reg  <= cmd.op;
                cnt_reg <= '0;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (cnt_reg == LAST)
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            acc_reg <= acc_init;
            b_reg   <= 32'(operand) << QW;
            q_reg   <= {1'b0, multiplier};
        end
        else if (run_reg)
        begin
            acc_reg <= take ? sum[31:0] : acc_reg;
            b_reg   <= b_reg >> 1;
            q_reg   <= {q_reg[QW-1:0], is_div ? sum[32] : 1'b0};
        end
    end

    assign done     = done_reg;
    assign acc      = acc_reg;
    assign quotient = q_reg;

endmodule

// ----- design/slab_next_table.sv -----
// Next-index memory of the free list, with a fill sweep after reset.
// No package dependencies.
module slab_next_table #(
    parameter int NUM_SLOTS = 32,
    parameter int IDX_W     = 6
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         rd_en,
    input  logic [$clog2(NUM_SLOTS)-1:0] rd_addr,
    output logic [IDX_W-1:0]             rd_data,
    input  logic                         wr_en,
    input  logic [$clog2(NUM_SLOTS)-1:0] wr_addr,
    input  logic [IDX_W-1:0]             wr_data,
    output logic                         init_busy
);

    localparam int            AW       = $clog2(NUM_SLOTS);
    localparam logic [AW-1:0] LAST_ROW = AW'(NUM_SLOTS - 1);

    logic [IDX_W-1:0] mem [NUM_SLOTS];
    logic [IDX_W-1:0] rd_data_reg;
    logic             fill_reg;
    logic [AW-1:0]    fill_ptr_reg;

    logic             we;
    logic [AW-1:0]    wa;
    logic [IDX_W-1:0] wd;

    // chain entry i to i+1 during the sweep; last entry gets the end marker
    always_comb
    begin
        if (fill_reg)
        begin
            we = 1'b1;
            wa = fill_ptr_reg;
            wd = IDX_W'(fill_ptr_reg) + IDX_W'(1);
        end
        else
        begin
            we = wr_en;
            wa = wr_addr;
            wd = wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg     <= 1'b1;
            fill_ptr_reg <= '0;
        end
        else if (fill_reg)
        begin
            if (fill_ptr_reg == LAST_ROW)
                fill_reg <= 1'b0;
            else
                fill_ptr_reg <= fill_ptr_reg + AW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
            mem[wa] <= wd;
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    assign rd_data   = rd_data_reg;
    assign init_busy = fill_reg;

endmodule

// ----- design/slab_free_list_allocator.sv -----
// Slab free-list allocator: one request in flight, one result per request.
// Allocate or free: the request starts the bit-per-cycle shift unit, and the result strobe is
// registered once the unit reports done; IDX_W = clog2(NUM_SLOTS+1). Empty results and frees
// at zero slot size arrive in the cycle after accept. A new request is taken in the result cycle.
// Reset: asynchronous, active low; then a sweep over all NUM_SLOTS entries chains the next-index
// table while busy stays high. The result strobe lasts one cycle and cannot be stalled.
module slab_free_list_allocator #(
    parameter int NUM_SLOTS = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  slab_pkg::req_t                      request,
    output logic                                busy,
    output logic                                done,
    output slab_pkg::res_t                      result,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [slab_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [31:0]                         cfg_data
);

    // IDX_W holds a slot index or the end marker; AW addresses the table
    localparam int               IDX_W = $clog2(NUM_SLOTS + 1);
    localparam int               AW    = $clog2(NUM_SLOTS);
    localparam logic [IDX_W-1:0] SLOTS = IDX_W'(NUM_SLOTS);
    localparam logic [IDX_W:0]   SLOTS_Q = (IDX_W + 1)'(NUM_SLOTS);

    // sequencer states
    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_ALLOC = 2'd1;
    localparam logic [1:0] S_FREE  = 2'd2;

    logic [1:0]       state_reg, state_next;
    logic [IDX_W-1:0] head_reg, head_next;
    logic [IDX_W-1:0] count_reg, count_next;
    logic             done_reg, done_next;
    slab_pkg::res_t   result_reg, result_next;
    logic [31:0]      base_reg;
    logic [15:0]      size_reg;

    logic                accept;
    logic [31:0]         offset;
    slab_pkg::unit_cmd_t ucmd;
    logic [31:0]         u_acc_init;
    logic                u_done;
    logic [31:0]         u_acc;
    logic [IDX_W:0]      u_quo;

    logic             rd_en;
    logic [IDX_W-1:0] rd_data;
    logic             wr_en;
    logic             init_busy;

    // pack one result; full is judged on the count after the operation
    function automatic slab_pkg::res_t make_res(
        input logic [1:0]       st,
        input logic [31:0]      a,
        input logic [IDX_W-1:0] num,
        input logic [IDX_W-1:0] cnt
    );
        slab_pkg::res_t r;
        r.status       = st;
        r.slot_address = a;
        r.slot_number  = 5'(num);
        r.free_count   = 6'(cnt);
        r.full_res     = (cnt == '0);
        return r;
    endfunction

    assign busy      = (state_reg != S_IDLE) || init_busy;
    assign accept    = start && !busy;
    assign cfg_ready = (state_reg == S_IDLE);
    assign offset    = request.addr - base_reg;

    always_comb
    begin
        state_next  = state_reg;
        head_next   = head_reg;
        count_next  = count_reg;
        done_next   = 1'b0;
        result_next = result_reg;
        ucmd.start  = 1'b0;
        ucmd.op     = slab_pkg::OP_MUL;
        u_acc_init  = base_reg;
        rd_en       = 1'b0;
        wr_en       = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (request.cmd == slab_pkg::CMD_ALLOC)
                    begin
                        if ((count_reg == '0) || (head_reg >= SLOTS))
                        begin
                            // nothing to hand out: report and leave the list alone
                            done_next   = 1'b1;
                            result_next = make_res(slab_pkg::ST_EMPTY, '0, '0, count_reg);
                        end
                        else
                        begin
                            // base + head * size in the unit; fetch the successor meanwhile
                            ucmd.start = 1'b1;
                            ucmd.op    = slab_pkg::OP_MUL;
                            rd_en      = 1'b1;
                            state_next = S_ALLOC;
                        end
                    end
                    else
                    begin
                        if (size_reg == '0)
                        begin
                            // zero slot size: the slab has no extent
                            done_next   = 1'b1;
                            result_next = make_res(slab_pkg::ST_BAD_ADDR, '0, '0, count_reg);
                        end
                        else
                        begin
                            ucmd.start = 1'b1;
                            ucmd.op    = slab_pkg::OP_DIV;
                            u_acc_init = offset;
                            state_next = S_FREE;
                        end
                    end
                end
            end

            S_ALLOC:
            begin
                if (u_done)
                begin
                    // pop the head
                    head_next   = rd_data;
                    count_next  = count_reg - IDX_W'(1);
                    done_next   = 1'b1;
                    result_next = make_res(slab_pkg::ST_OK, u_acc, head_reg, count_next);
                    state_next  = S_IDLE;
                end
            end

            S_FREE:
            begin
                if (u_done)
                begin
                    // quotient past the last slot means the offset is beyond the slab
                    if (u_quo >= SLOTS_Q)
                    begin
                        result_next = make_res(slab_pkg::ST_BAD_ADDR, '0, '0, count_reg);
                    end
                    else
                    begin
                        // push the slot; count saturates on a double free
                        wr_en     = 1'b1;
                        head_next = u_quo[IDX_W-1:0];
                        if (count_reg < SLOTS)
                            count_next = count_reg + IDX_W'(1);
                        result_next = make_res(slab_pkg::ST_OK, '0, u_quo[IDX_W-1:0],
                                               count_next);
                    end
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            head_reg  <= '0;
            count_reg <= SLOTS;
            done_reg  <= 1'b0;
            base_reg  <= slab_pkg::BASE_RESET;
            size_reg  <= slab_pkg::SIZE_RESET;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            count_reg <= count_next;
            done_reg  <= done_next;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    slab_pkg::CFG_BASE_ADDRESS: base_reg <= cfg_data;
                    slab_pkg::CFG_SLOT_SIZE:    size_reg <= cfg_data[15:0];
                    default:                    ;
                endcase
            end
        end
    end

    // result payload; qualified by the strobe
    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

    slab_shift_unit #(
        .QW(IDX_W)
    ) u_unit (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (ucmd),
        .acc_init   (u_acc_init),
        .operand    (size_reg),
        .multiplier (head_reg),
        .done       (u_done),
        .acc        (u_acc),
        .quotient   (u_quo)
    );

    slab_next_table #(
        .NUM_SLOTS(NUM_SLOTS),
        .IDX_W    (IDX_W)
    ) u_table (
        .clk       (clk),
        .rst_n     (rst_n),
        .rd_en     (rd_en),
        .rd_addr   (head_reg[AW-1:0]),
        .rd_data   (rd_data),
        .wr_en     (wr_en),
        .wr_addr   (u_quo[AW-1:0]),
        .wr_data   (head_reg),
        .init_busy (init_busy)
    );

endmodule

// ----- design/slab_checker.sv -----
// Port-level checks for the slab allocator, bound to the top level.
// Depends on slab_pkg and the assertion macros header.
`include "slab_free_list_allocator_defines.svh"

module slab_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           start,
    input logic           busy,
    input logic           done,
    input slab_pkg::res_t result,
    input logic           cfg_ready
);

    `SLAB_ASSERT_NOW(a_done_not_busy, done, !busy, "result strobe while busy")
    `SLAB_ASSERT_NEXT(a_accept_moves, start && !busy, done || busy, "request accepted but dropped")
    `SLAB_ASSERT_NOW(a_err_zero, done && (result.status != slab_pkg::ST_OK), (result.slot_address == '0) && (result.slot_number == '0), "error result carries a slot")
    `SLAB_ASSERT_NOW(a_cfg_idle, !cfg_ready, busy, "config held off while idle")

endmodule

bind slab_free_list_allocator slab_checker u_slab_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .done      (done),
    .result    (result),
    .cfg_ready (cfg_ready)
);
